/* rtl/core/oaa_pkg.sv */
// Shared types and constants for the oversampled ADC averager.
`timescale 1ns / 1ps
package oaa_pkg;

    localparam int RAW_W  = 12;
    localparam int SUM_W  = 20;
    localparam int CNT_W  = 8;
    localparam int VREF_W = 16;
    localparam int MV_W   = 16;
    localparam int TS_W   = 32;
    localparam int CHAN_W = 3;
    localparam int ACC_W  = RAW_W + VREF_W;

    localparam int APB_DW = 32;
    localparam int APB_AW = 4;

    localparam logic [CHAN_W-1:0] CHANNEL_RST = CHAN_W'(0);
    localparam logic [VREF_W-1:0] VREF_RST    = VREF_W'(3300);
    localparam logic [CNT_W-1:0]  COUNT_RST   = CNT_W'(1);
    localparam logic              ASMV_RST    = 1'b1;

    // rounding bias and divisor of the millivolt scaling
    localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(2047);
    localparam logic [RAW_W-1:0] MV_DIVISOR = RAW_W'(4095);

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_RAW   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        STS_OK          = 2'd0,
        STS_BAD_ARG     = 2'd1,
        STS_NOT_INIT    = 2'd2,
        STS_NOT_STARTED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        REG_CHANNEL = 2'd0,
        REG_VREF    = 2'd1,
        REG_COUNT   = 2'd2,
        REG_ASMV    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [CNT_W-1:0]  count;
        logic [VREF_W-1:0] vref;
        logic              asmv;
    } t_calc_req;

    typedef struct packed {
        logic              done;
        logic [RAW_W-1:0]  avg;
        logic [MV_W-1:0]   mv;
    } t_calc_rsp;

endpackage

/* rtl/core/oaa_calc.sv */
// Bit-serial average divider, shift-add multiplier and millivolt divider.
`timescale 1ns / 1ps
module oaa_calc (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  oaa_pkg::t_calc_req  i_req,
    output oaa_pkg::t_calc_rsp  o_rsp
);

    localparam int RAW_W  = oaa_pkg::RAW_W;
    localparam int SUM_W  = oaa_pkg::SUM_W;
    localparam int CNT_W  = oaa_pkg::CNT_W;
    localparam int VREF_W = oaa_pkg::VREF_W;
    localparam int MV_W   = oaa_pkg::MV_W;
    localparam int ACC_W  = oaa_pkg::ACC_W;
    localparam int REM_W  = RAW_W;
    localparam int DVD_W  = MV_W;
    localparam int STEP_W = $clog2(DVD_W + 1);

    localparam logic [STEP_W-1:0] AVG_STEPS = STEP_W'(RAW_W);
    localparam logic [STEP_W-1:0] MUL_STEPS = STEP_W'(RAW_W);
    localparam logic [STEP_W-1:0] MV_STEPS  = STEP_W'(MV_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_AVG,
        S_MUL,
        S_ROUND,
        S_MV
    } t_state;

    t_state              r_state;
    logic [REM_W-1:0]    r_rem;
    logic [DVD_W-1:0]    r_dvd;
    logic [REM_W-1:0]    r_dsr;
    logic [STEP_W-1:0]   r_step;
    logic [ACC_W-1:0]    r_acc;
    logic [RAW_W-1:0]    r_mplr;
    logic [VREF_W-1:0]   r_vref;
    logic                r_asmv;
    logic [RAW_W-1:0]    r_avg;
    logic [MV_W-1:0]     r_mv;
    logic                r_done;

    logic [REM_W:0]      w_rem_sh;
    logic [REM_W+1:0]    w_diff;
    logic                w_ge;
    logic [REM_W-1:0]    w_rem_nx;
    logic [DVD_W-1:0]    w_dvd_nx;
    logic [ACC_W-1:0]    w_acc_mul;
    logic [ACC_W-1:0]    w_acc_rnd;
    logic                w_last;

    // one restoring-division step, shared by both divisions
    assign w_rem_sh = {r_rem, r_dvd[DVD_W-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_dsr};
    assign w_ge     = ~w_diff[REM_W+1];
    assign w_rem_nx = w_ge ? w_diff[REM_W-1:0] : w_rem_sh[REM_W-1:0];
    assign w_dvd_nx = {r_dvd[DVD_W-2:0], w_ge};

    // MSB-first shift-add
    assign w_acc_mul = {r_acc[ACC_W-2:0], 1'b0}
                     + (r_mplr[RAW_W-1] ? {{(ACC_W-VREF_W){1'b0}}, r_vref} : '0);
    assign w_acc_rnd = r_acc + oaa_pkg::ROUND_BIAS;
    assign w_last    = (r_step == STEP_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        // sum < count*4096, so the top bits start below the divisor
                        r_rem  <= {{(REM_W-(SUM_W-RAW_W)){1'b0}}, i_req.sum[SUM_W-1:RAW_W]};
                        r_dvd  <= {i_req.sum[RAW_W-1:0], {(DVD_W-RAW_W){1'b0}}};
                        r_dsr  <= {{(REM_W-CNT_W){1'b0}}, i_req.count};
                        r_vref <= i_req.vref;
                        r_asmv <= i_req.asmv;
                        r_step <= AVG_STEPS;
                        r_state <= S_AVG;
                    end
                end
                S_AVG: begin
                    r_rem  <= w_rem_nx;
                    r_dvd  <= w_dvd_nx;
                    r_done <= w_last & ~r_asmv;
                    if (w_last) begin
                        r_avg <= w_dvd_nx[RAW_W-1:0];
                        if (r_asmv) begin
                            r_mplr  <= w_dvd_nx[RAW_W-1:0];
                            r_acc   <= '0;
                            r_step  <= MUL_STEPS;
                            r_state <= S_MUL;
                        end else begin
                            r_mv    <= '0;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_step <= r_step - STEP_W'(1);
                    end
                end
                S_MUL: begin
                    r_done <= 1'b0;
                    r_acc  <= w_acc_mul;
                    r_mplr <= {r_mplr[RAW_W-2:0], 1'b0};
                    r_step <= r_step - STEP_W'(1);
                    if (w_last) begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    // dividend < 4095 * 2^16, so the quotient fits 16 bits
                    r_done  <= 1'b0;
                    r_rem   <= w_acc_rnd[ACC_W-1:DVD_W];
                    r_dvd   <= w_acc_rnd[DVD_W-1:0];
                    r_dsr   <= oaa_pkg::MV_DIVISOR;
                    r_step  <= MV_STEPS;
                    r_state <= S_MV;
                end
                S_MV: begin
                    r_rem  <= w_rem_nx;
                    r_dvd  <= w_dvd_nx;
                    r_step <= r_step - STEP_W'(1);
                    r_done <= w_last;
                    if (w_last) begin
                        r_mv    <= w_dvd_nx;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.avg  = r_avg;
    assign o_rsp.mv   = r_mv;

endmodule

/* rtl/core/oversampled_adc_averager.sv */
// Top level of the oversampled ADC averager: command handling, config port, result register.
`timescale 1ns / 1ps
// Commands are taken one at a time. Stop and a conversion that does not complete the
// oversample count leave the block idle and can arrive back to back. Init, start and a
// rejected conversion pass through the emit state, which puts a status result into the
// output register once it is free, so such commands are never taken back to back.
// A conversion that completes the count runs the bit-serial arithmetic: an average
// divide, then with millivolt scaling enabled a shift-add multiply, a rounding step and a
// divide by 4095; the result then enters the output register through the emit state once
// that register is free. A finished result waits in the output register while the
// next command is taken.
module oversampled_adc_averager (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_opcode,
    input  logic [oaa_pkg::RAW_W-1:0]     i_raw_sample,
    input  logic [oaa_pkg::TS_W-1:0]      i_timestamp_us,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status,
    output logic [oaa_pkg::RAW_W-1:0]     o_average_raw,
    output logic [oaa_pkg::MV_W-1:0]      o_millivolt,
    output logic [oaa_pkg::TS_W-1:0]      o_sample_time_us,
    output logic                          o_sample_valid,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [oaa_pkg::APB_AW-1:0]    paddr,
    input  logic [oaa_pkg::APB_DW-1:0]    pwdata,
    output logic [oaa_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int RAW_W  = oaa_pkg::RAW_W;
    localparam int SUM_W  = oaa_pkg::SUM_W;
    localparam int CNT_W  = oaa_pkg::CNT_W;
    localparam int VREF_W = oaa_pkg::VREF_W;
    localparam int MV_W   = oaa_pkg::MV_W;
    localparam int TS_W   = oaa_pkg::TS_W;
    localparam int CHAN_W = oaa_pkg::CHAN_W;
    localparam int APB_DW = oaa_pkg::APB_DW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_EMIT
    } t_state;

    // configuration
    logic [CHAN_W-1:0]    r_cfg_channel;
    logic [VREF_W-1:0]    r_cfg_vref;
    logic [CNT_W-1:0]     r_cfg_count;
    logic                 r_cfg_asmv;

    // run state
    t_state               r_state;
    logic                 r_is_init;
    logic                 r_is_started;
    logic [SUM_W-1:0]     r_sum;
    logic [CNT_W-1:0]     r_taken;
    logic [VREF_W-1:0]    r_run_vref;
    logic [CNT_W-1:0]     r_run_count;
    logic                 r_run_asmv;

    // pending and output results
    oaa_pkg::t_status     r_pend_status;
    logic                 r_pend_sv;
    logic [TS_W-1:0]      r_pend_ts;
    logic                 r_out_valid;
    oaa_pkg::t_status     r_out_status;
    logic [RAW_W-1:0]     r_out_avg;
    logic [MV_W-1:0]      r_out_mv;
    logic [TS_W-1:0]      r_out_ts;
    logic                 r_out_sv;

    logic                 w_cfg_wr;
    oaa_pkg::t_reg_idx    w_cfg_idx;
    logic                 w_accept;
    logic [SUM_W-1:0]     w_sum_nx;
    logic [CNT_W-1:0]     w_taken_nx;
    logic                 w_complete;
    logic                 w_calc_start;
    logic                 w_slot_free;
    oaa_pkg::t_calc_req   w_req;
    oaa_pkg::t_calc_rsp   w_rsp;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite & pready;
    assign w_cfg_idx = oaa_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_channel <= oaa_pkg::CHANNEL_RST;
            r_cfg_vref    <= oaa_pkg::VREF_RST;
            r_cfg_count   <= oaa_pkg::COUNT_RST;
            r_cfg_asmv    <= oaa_pkg::ASMV_RST;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                oaa_pkg::REG_CHANNEL: r_cfg_channel <= pwdata[CHAN_W-1:0];
                oaa_pkg::REG_VREF:    r_cfg_vref    <= pwdata[VREF_W-1:0];
                oaa_pkg::REG_COUNT:   r_cfg_count   <= pwdata[CNT_W-1:0];
                oaa_pkg::REG_ASMV:    r_cfg_asmv    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            oaa_pkg::REG_CHANNEL: prdata = APB_DW'(r_cfg_channel);
            oaa_pkg::REG_VREF:    prdata = APB_DW'(r_cfg_vref);
            oaa_pkg::REG_COUNT:   prdata = APB_DW'(r_cfg_count);
            oaa_pkg::REG_ASMV:    prdata = APB_DW'(r_cfg_asmv);
            default:              prdata = '0;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid & o_in_ready;
    assign w_sum_nx    = r_sum + {{(SUM_W-RAW_W){1'b0}}, i_raw_sample};
    assign w_taken_nx  = r_taken + CNT_W'(1);
    // run count is non-zero once initialised
    assign w_complete  = (w_taken_nx >= r_run_count);
    assign w_calc_start = w_accept && (oaa_pkg::t_opcode'(i_opcode) == oaa_pkg::OP_RAW)
                        && r_is_init && r_is_started && w_complete;
    assign w_slot_free = ~r_out_valid | i_out_ready;

    assign w_req.sum   = w_sum_nx;
    assign w_req.count = r_run_count;
    assign w_req.vref  = r_run_vref;
    assign w_req.asmv  = r_run_asmv;

    oaa_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_calc_start),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_is_init    <= 1'b0;
            r_is_started <= 1'b0;
            r_sum        <= '0;
            r_taken      <= '0;
            r_run_vref   <= '0;
            r_run_count  <= '0;
            r_run_asmv   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // in S_EMIT a drained register is reloaded below instead
            if (r_out_valid && i_out_ready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_pend_sv <= w_calc_start;
                        r_pend_ts <= w_calc_start ? i_timestamp_us : '0;
                        case (oaa_pkg::t_opcode'(i_opcode))
                            oaa_pkg::OP_INIT: begin
                                r_state <= S_EMIT;
                                if (r_cfg_vref == '0 || r_cfg_count == '0) begin
                                    r_pend_status <= oaa_pkg::STS_BAD_ARG;
                                end else begin
                                    r_pend_status <= oaa_pkg::STS_OK;
                                    r_is_init     <= 1'b1;
                                    r_is_started  <= 1'b0;
                                    r_sum         <= '0;
                                    r_taken       <= '0;
                                    r_run_vref    <= r_cfg_vref;
                                    r_run_count   <= r_cfg_count;
                                    r_run_asmv    <= r_cfg_asmv;
                                end
                            end
                            oaa_pkg::OP_START: begin
                                r_state <= S_EMIT;
                                if (!r_is_init) begin
                                    r_pend_status <= oaa_pkg::STS_NOT_INIT;
                                end else begin
                                    r_pend_status <= oaa_pkg::STS_OK;
                                    r_is_started  <= 1'b1;
                                end
                            end
                            oaa_pkg::OP_STOP: begin
                                r_is_started <= 1'b0;
                                r_sum        <= '0;
                                r_taken      <= '0;
                            end
                            oaa_pkg::OP_RAW: begin
                                if (!r_is_init) begin
                                    r_pend_status <= oaa_pkg::STS_NOT_INIT;
                                    r_state       <= S_EMIT;
                                end else if (!r_is_started) begin
                                    r_pend_status <= oaa_pkg::STS_NOT_STARTED;
                                    r_state       <= S_EMIT;
                                end else if (w_complete) begin
                                    r_pend_status <= oaa_pkg::STS_OK;
                                    r_sum         <= '0;
                                    r_taken       <= '0;
                                    r_state       <= S_CALC;
                                end else begin
                                    r_sum   <= w_sum_nx;
                                    r_taken <= w_taken_nx;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_CALC: begin
                    if (w_rsp.done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_slot_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_pend_status;
                        r_out_avg    <= r_pend_sv ? w_rsp.avg : '0;
                        r_out_mv     <= r_pend_sv ? w_rsp.mv : '0;
                        r_out_ts     <= r_pend_ts;
                        r_out_sv     <= r_pend_sv;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_average_raw    = r_out_avg;
    assign o_millivolt      = r_out_mv;
    assign o_sample_time_us = r_out_ts;
    assign o_sample_valid   = r_out_sv;

    a_started_needs_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_is_started |-> r_is_init)
        else $error("started without init");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_is_init |-> (r_run_count != '0 && r_taken < r_run_count))
        else $error("sample count outside the run count");

    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_CALC))
        else $error("arithmetic finished outside the calc wait");

    a_start_enters_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_calc_start |=> (r_state == S_CALC && !w_rsp.done))
        else $error("calc start did not enter the calc wait");

endmodule

/* dv/oversampled_adc_averager_tb.sv */
// Self-checking testbench for the oversampled ADC averager: command stimulus, APB setup, scoreboard.
`timescale 1ns / 1ps
module oversampled_adc_averager_tb;

    localparam int RAW_W  = oaa_pkg::RAW_W;
    localparam int SUM_W  = oaa_pkg::SUM_W;
    localparam int CNT_W  = oaa_pkg::CNT_W;
    localparam int VREF_W = oaa_pkg::VREF_W;
    localparam int MV_W   = oaa_pkg::MV_W;
    localparam int TS_W   = oaa_pkg::TS_W;
    localparam int CHAN_W = oaa_pkg::CHAN_W;
    localparam int APB_DW = oaa_pkg::APB_DW;
    localparam int APB_AW = oaa_pkg::APB_AW;

    typedef struct {
        oaa_pkg::t_status  status;
        logic [RAW_W-1:0]  avg;
        logic [MV_W-1:0]   mv;
        logic [TS_W-1:0]   stamp;
        logic              valid;
    } t_reading;

    // Tracks the averager's command state and the readings it owes.
    class t_averager_scoreboard;
        bit [CHAN_W-1:0] chan_reg  = oaa_pkg::CHANNEL_RST;
        bit [VREF_W-1:0] vref_reg  = oaa_pkg::VREF_RST;
        bit [CNT_W-1:0]  count_reg = oaa_pkg::COUNT_RST;
        bit              asmv_reg  = oaa_pkg::ASMV_RST;

        bit              initialised;
        bit              started;
        bit [SUM_W-1:0]  sum;
        bit [CNT_W-1:0]  taken;
        bit [VREF_W-1:0] run_vref;
        bit [CNT_W-1:0]  run_count;
        bit              run_asmv;

        t_reading        expected_readings[$];
        int              errors;

        function int pending();
            return expected_readings.size();
        endfunction

        function void set_reg(oaa_pkg::t_reg_idx idx, bit [APB_DW-1:0] value);
            case (idx)
                oaa_pkg::REG_CHANNEL: chan_reg  = value[CHAN_W-1:0];
                oaa_pkg::REG_VREF:    vref_reg  = value[VREF_W-1:0];
                oaa_pkg::REG_COUNT:   count_reg = value[CNT_W-1:0];
                oaa_pkg::REG_ASMV:    asmv_reg  = value[0];
                default: ;
            endcase
        endfunction

        task flag_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function void note_command(oaa_pkg::t_opcode op, logic [RAW_W-1:0] raw,
                                   logic [TS_W-1:0] stamp);
            t_reading r;
            r.status = oaa_pkg::STS_OK;
            r.avg    = '0;
            r.mv     = '0;
            r.stamp  = '0;
            r.valid  = 1'b0;
            case (op)
                oaa_pkg::OP_INIT: begin
                    if (vref_reg == 0 || count_reg == 0) begin
                        r.status = oaa_pkg::STS_BAD_ARG;
                    end else begin
                        initialised = 1'b1;
                        started     = 1'b0;
                        sum         = '0;
                        taken       = '0;
                        run_vref    = vref_reg;
                        run_count   = count_reg;
                        run_asmv    = asmv_reg;
                    end
                    expected_readings.push_back(r);
                end
                oaa_pkg::OP_START: begin
                    if (!initialised)
                        r.status = oaa_pkg::STS_NOT_INIT;
                    else
                        started = 1'b1;
                    expected_readings.push_back(r);
                end
                oaa_pkg::OP_STOP: begin
                    started = 1'b0;
                    sum     = '0;
                    taken   = '0;
                end
                default: begin
                    if (!initialised) begin
                        r.status = oaa_pkg::STS_NOT_INIT;
                        expected_readings.push_back(r);
                    end else if (!started) begin
                        r.status = oaa_pkg::STS_NOT_STARTED;
                        expected_readings.push_back(r);
                    end else begin
                        sum   = sum + raw;
                        taken = taken + 1'b1;
                        if (run_count != 0 && taken >= run_count) begin
                            r.avg = RAW_W'(sum / run_count);
                            if (run_asmv)
                                r.mv = MV_W'((32'(r.avg) * 32'(run_vref)
                                              + 32'(oaa_pkg::ROUND_BIAS))
                                             / 32'(oaa_pkg::MV_DIVISOR));
                            r.stamp = stamp;
                            r.valid = 1'b1;
                            sum     = '0;
                            taken   = '0;
                            expected_readings.push_back(r);
                        end
                    end
                end
            endcase
        endfunction

        task check_reading(logic [1:0] status, logic [RAW_W-1:0] avg, logic [MV_W-1:0] mv,
                           logic [TS_W-1:0] stamp, logic valid);
            t_reading want;
            if (expected_readings.size() == 0) begin
                flag_mismatch("result with nothing outstanding");
                return;
            end
            want = expected_readings.pop_front();
            if (status !== want.status)
                flag_mismatch($sformatf("status got %0d want %0d", status, want.status));
            if (avg !== want.avg)
                flag_mismatch($sformatf("average_raw got %0d want %0d", avg, want.avg));
            if (mv !== want.mv)
                flag_mismatch($sformatf("millivolt got %0d want %0d", mv, want.mv));
            if (stamp !== want.stamp)
                flag_mismatch($sformatf("sample_time_us got %0h want %0h", stamp, want.stamp));
            if (valid !== want.valid)
                flag_mismatch($sformatf("sample_valid got %0b want %0b", valid, want.valid));
        endtask
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [1:0]          i_opcode;
    logic [RAW_W-1:0]    i_raw_sample;
    logic [TS_W-1:0]     i_timestamp_us;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [1:0]          o_status;
    logic [RAW_W-1:0]    o_average_raw;
    logic [MV_W-1:0]     o_millivolt;
    logic [TS_W-1:0]     o_sample_time_us;
    logic                o_sample_valid;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    t_averager_scoreboard sb = new();

    int items_sent;
    int snd_idle_pct = 36;
    int rcv_idle_pct = 53;
    int hold_requests;
    int holds_served;
    int hold_left;

    oversampled_adc_averager i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_raw_sample     (i_raw_sample),
        .i_timestamp_us   (i_timestamp_us),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_average_raw    (o_average_raw),
        .o_millivolt      (o_millivolt),
        .o_sample_time_us (o_sample_time_us),
        .o_sample_valid   (o_sample_valid),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #5 i_clk = ~i_clk;

    // Result side back-pressure; a hold request blocks the output for a long stretch.
    always @(posedge i_clk) begin
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = 400;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_reading(o_status, o_average_raw, o_millivolt, o_sample_time_us,
                             o_sample_valid);
    end

    function automatic logic [RAW_W-1:0] rand_raw();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return RAW_W'($urandom);
        endcase
    endfunction

    task automatic send_cmd(oaa_pkg::t_opcode op, logic [RAW_W-1:0] raw,
                            logic [TS_W-1:0] stamp);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_raw_sample   <= raw;
        i_timestamp_us <= stamp;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_command(op, raw, stamp);
        items_sent++;
        // receiver-heavy idling, then sender-heavy, then none
        if (items_sent < 500) begin
            snd_idle_pct = 36;
            rcv_idle_pct = 53;
        end else if (items_sent < 1000) begin
            snd_idle_pct = 53;
            rcv_idle_pct = 36;
        end else begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
        end
    endtask

    task automatic drain_readings();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (sb.pending() != 0 && guard < 200000);
        if (sb.pending() != 0)
            sb.flag_mismatch($sformatf("%0d results never arrived", sb.pending()));
    endtask

    task automatic apb_write(oaa_pkg::t_reg_idx idx, logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Only reconfigure once the block has finished all outstanding work.
    task automatic configure(int chan, int vref, int count, int asmv);
        drain_readings();
        repeat (60) @(posedge i_clk);
        apb_write(oaa_pkg::REG_CHANNEL, chan);
        apb_write(oaa_pkg::REG_VREF, vref);
        apb_write(oaa_pkg::REG_COUNT, count);
        apb_write(oaa_pkg::REG_ASMV, asmv);
    endtask

    // Mostly init/start/conversion runs with random data, plus stray commands.
    task automatic run_traffic(int n);
        int first;
        int burst;
        int stop_at;
        int base;
        first = items_sent;
        while (items_sent - first < n) begin
            if ($urandom_range(0, 99) < 10) begin
                send_cmd(oaa_pkg::t_opcode'($urandom_range(0, 3)), RAW_W'($urandom), $urandom);
            end else begin
                if ($urandom_range(0, 1))
                    send_cmd(oaa_pkg::OP_INIT, RAW_W'($urandom), $urandom);
                send_cmd(oaa_pkg::OP_START, RAW_W'($urandom), $urandom);
                base    = (sb.run_count != 0) ? sb.run_count : 4;
                burst   = $urandom_range(1, 2 * base + 2);
                stop_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, burst - 1) : -1;
                for (int k = 0; k < burst; k++) begin
                    if (k == stop_at)
                        send_cmd(oaa_pkg::OP_STOP, RAW_W'($urandom), $urandom);
                    else
                        send_cmd(oaa_pkg::OP_RAW, rand_raw(), $urandom);
                end
            end
        end
    endtask

    initial begin
        int vref;
        int count;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_opcode       <= oaa_pkg::OP_INIT;
        i_raw_sample   <= '0;
        i_timestamp_us <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // commands before init, then a basic init/start/convert flow at reset settings
        send_cmd(oaa_pkg::OP_RAW, 12'd5, 32'd1);
        send_cmd(oaa_pkg::OP_START, '0, '0);
        send_cmd(oaa_pkg::OP_STOP, '0, '0);
        send_cmd(oaa_pkg::OP_INIT, '0, '0);
        send_cmd(oaa_pkg::OP_RAW, 12'd7, 32'd2);
        send_cmd(oaa_pkg::OP_START, '0, '0);
        send_cmd(oaa_pkg::OP_RAW, 12'hFFF, 32'hFFFF_FFFF);
        send_cmd(oaa_pkg::OP_RAW, 12'h000, 32'h0000_0000);
        send_cmd(oaa_pkg::OP_STOP, '1, '1);
        send_cmd(oaa_pkg::OP_RAW, 12'h555, 32'h5555_5555);
        send_cmd(oaa_pkg::OP_START, '0, '0);
        send_cmd(oaa_pkg::OP_INIT, 12'hAAA, 32'hAAAA_AAAA);
        send_cmd(oaa_pkg::OP_RAW, 12'h123, 32'd3);

        // zero reference or zero count is rejected and leaves the state alone
        configure(7, 0, 4, 1);
        send_cmd(oaa_pkg::OP_INIT, '0, '0);
        send_cmd(oaa_pkg::OP_RAW, 12'd9, 32'd4);
        configure(0, 65535, 0, 1);
        send_cmd(oaa_pkg::OP_INIT, '0, '0);

        // scaling off, one full conversion, then a partial accumulation cut short by stop
        configure(0, 65535, 3, 0);
        send_cmd(oaa_pkg::OP_INIT, '0, '0);
        send_cmd(oaa_pkg::OP_START, '0, '0);
        send_cmd(oaa_pkg::OP_RAW, 12'hFFF, 32'd10);
        send_cmd(oaa_pkg::OP_RAW, 12'hFFF, 32'd11);
        send_cmd(oaa_pkg::OP_RAW, 12'hFFF, 32'd12);
        send_cmd(oaa_pkg::OP_RAW, 12'd100, 32'd13);
        send_cmd(oaa_pkg::OP_STOP, '0, '0);

        configure(7, 65535, 255, 1);
        run_traffic(200);
        configure(0, 1, 1, 1);
        run_traffic(100);
        configure($urandom_range(0, 7), 0, $urandom_range(1, 8), 1);
        run_traffic(100);
        configure($urandom_range(0, 7), 65535, 0, 0);
        run_traffic(100);

        for (int ph = 4; ph < 14; ph++) begin
            vref  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 65535);
            count = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
            configure($urandom_range(0, 7), vref, count, $urandom_range(0, 1));
            if (ph == 4) begin
                send_cmd(oaa_pkg::OP_INIT, '0, '0);
                hold_requests++;
            end
            if (ph == 6) begin
                run_traffic(50);
                drain_readings();
                run_traffic(50);
            end else begin
                run_traffic(100);
            end
        end

        drain_readings();
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* oversampled_adc_averager.f */
rtl/core/oaa_pkg.sv
rtl/core/oaa_calc.sv
rtl/core/oversampled_adc_averager.sv
dv/oversampled_adc_averager_tb.sv
